FILE: rtl/isoc_pkg.sv
`default_nettype none

package isoc_pkg;

	// pixel classes
	typedef logic [1:0] class_t;
	localparam class_t CLASS_BACKGROUND = 2'd0;
	localparam class_t CLASS_OBJECT     = 2'd1;

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// register widths and reset values
	localparam int     DIM_W        = 11;
	localparam int     MIN_DIM      = 4;
	localparam int     MAX_HEIGHT   = 1024;
	localparam int     ROW_W        = 10;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd13;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd7;

	// match counter
	localparam int COUNT_W = 18;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 18'h3FFFF;

	// window geometry
	localparam int WIN = 4;

	// one column entering the window: index 0 is three rows up, 3 is the new pixel
	typedef class_t [WIN-1:0] column_t;

	typedef struct packed {
		class_t pixel_class;
	} in_item_t;

	typedef struct packed {
		logic               window_match;
		logic [COUNT_W-1:0] object_count;
		logic               frame_end;
	} out_item_t;

endpackage

`default_nettype wire

FILE: rtl/isoc_stream_if.sv
`default_nettype none

interface isoc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/isoc_ram.sv
`default_nettype none

module isoc_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/isoc_cell.sv
`default_nettype none

// One window cell: holds a pixel class and takes its right neighbor's value.
module isoc_cell (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire isoc_pkg::class_t d,
	output isoc_pkg::class_t      q
);

	isoc_pkg::class_t val_q;

	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

`default_nettype wire

FILE: rtl/isoc_window.sv
`default_nettype none

// 4x4 window as four rows of shifting cells, with the hit-or-miss compare.
module isoc_window (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire isoc_pkg::column_t col_in,
	output logic                   match_next
);

	isoc_pkg::class_t cell_q   [isoc_pkg::WIN][isoc_pkg::WIN];
	isoc_pkg::class_t next_win [isoc_pkg::WIN][isoc_pkg::WIN];

	// each row shifts left; the new column enters at the right end
	for (genvar r = 0; r < isoc_pkg::WIN; r++) begin : g_row
		for (genvar c = 0; c < isoc_pkg::WIN; c++) begin : g_col
			if (c == isoc_pkg::WIN - 1) begin : g_edge
				assign next_win[r][c] = col_in[r];
			end else begin : g_inner
				assign next_win[r][c] = cell_q[r][c+1];
			end
			isoc_cell u_cell (
				.clk (clk),
				.en  (en),
				.d   (next_win[r][c]),
				.q   (cell_q[r][c])
			);
		end
	end

	// center 2x2 object, ring background, checked on the window after the shift
	always_comb begin
		match_next = 1'b1;
		for (int r = 0; r < isoc_pkg::WIN; r++) begin
			for (int c = 0; c < isoc_pkg::WIN; c++) begin
				if ((r == 1 || r == 2) && (c == 1 || c == 2)) begin
					if (next_win[r][c] != isoc_pkg::CLASS_OBJECT) begin
						match_next = 1'b0;
					end
				end else begin
					if (next_win[r][c] != isoc_pkg::CLASS_BACKGROUND) begin
						match_next = 1'b0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/isolated_square_object_counter_unit.sv
// Path: a pixel passes the stage 1 register and then the output register.
// Throughput: one pixel per cycle while result_out accepts results; the
// line store does one read and one write per cycle and the window cells
// shift once per pixel.
// Reset: asynchronous, active low. After reset the line store is cleared
// one column per cycle across MAX_WIDTH columns (1024 by default) and no
// pixel is taken meanwhile; configuration writes are taken at any time.
`default_nettype none

module isolated_square_object_counter_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [isoc_pkg::DIM_W-1:0]  cfg_data,
	isoc_stream_if.sink                      pixel_in,
	isoc_stream_if.source                    result_out
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int LW = ((CW > isoc_pkg::DIM_W) ? CW : isoc_pkg::DIM_W) + 1;
	localparam int HW = isoc_pkg::DIM_W + 1;

	// configuration registers
	logic [isoc_pkg::DIM_W-1:0] width_q;
	logic [isoc_pkg::DIM_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= isoc_pkg::WIDTH_RESET;
			height_q <= isoc_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				isoc_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				isoc_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped last column and last row
	logic [LW-1:0] width_ext;
	logic [LW-1:0] col_last;
	logic [HW-1:0] height_ext;
	logic [HW-1:0] row_last;

	always_comb begin
		width_ext = LW'(width_q);
		if (width_ext < LW'(isoc_pkg::MIN_DIM)) begin
			col_last = LW'(isoc_pkg::MIN_DIM - 1);
		end else if (width_ext > LW'(MAX_WIDTH)) begin
			col_last = LW'(MAX_WIDTH - 1);
		end else begin
			col_last = width_ext - LW'(1);
		end
		height_ext = HW'(height_q);
		if (height_ext < HW'(isoc_pkg::MIN_DIM)) begin
			row_last = HW'(isoc_pkg::MIN_DIM - 1);
		end else if (height_ext > HW'(isoc_pkg::MAX_HEIGHT)) begin
			row_last = HW'(isoc_pkg::MAX_HEIGHT - 1);
		end else begin
			row_last = height_ext - HW'(1);
		end
	end

	// line store clearing pass after reset
	logic          clr_busy_q;
	logic [CW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + CW'(1);
		end
	end

	// handshake and pipeline control
	logic                s1_valid_q;
	logic                out_valid_q;
	logic                s1_adv;
	logic                in_ready;
	logic                in_fire;

	assign s1_adv   = s1_valid_q && (!out_valid_q || result_out.ready);
	assign in_ready = !clr_busy_q && (!s1_valid_q || s1_adv);
	assign in_fire  = pixel_in.valid && in_ready;
	assign pixel_in.ready = in_ready;

	// frame position
	logic [CW-1:0]            col_q;
	logic [isoc_pkg::ROW_W-1:0] row_q;
	logic                     last_col;
	logic                     last_row;

	assign last_col = LW'(col_q) >= col_last;
	assign last_row = HW'(row_q) >= row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + isoc_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: pixel waits for its line store column
	isoc_pkg::class_t px_s1;
	logic [CW-1:0]    col_s1;
	logic             inside_s1;
	logic             end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1     <= pixel_in.data.pixel_class;
			col_s1    <= col_q;
			inside_s1 <= (row_q >= isoc_pkg::ROW_W'(3)) && (col_q >= CW'(3));
			end_s1    <= last_col && last_row;
		end
	end

	// line store: one word per column holds the three rows above
	logic [3*2-1:0] ls_rdata;
	logic [3*2-1:0] ls_wdata;
	logic [CW-1:0]  ls_waddr;
	logic           ls_we;

	assign ls_we    = clr_busy_q || s1_adv;
	assign ls_waddr = clr_busy_q ? clr_addr_q : col_s1;
	assign ls_wdata = clr_busy_q ? '0 : {ls_rdata[3:2], ls_rdata[1:0], px_s1};

	isoc_ram #(
		.WIDTH (3 * 2),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ls_we),
		.waddr (ls_waddr),
		.wdata (ls_wdata),
		.re    (in_fire),
		.raddr (col_q),
		.rdata (ls_rdata)
	);

	// window cells
	isoc_pkg::column_t win_col;
	logic              match_next;

	assign win_col = {px_s1, ls_rdata[1:0], ls_rdata[3:2], ls_rdata[5:4]};

	isoc_window u_window (
		.clk        (clk),
		.en         (s1_adv),
		.col_in     (win_col),
		.match_next (match_next)
	);

	// saturating match count
	logic                         hit;
	logic [isoc_pkg::COUNT_W-1:0] total_q;
	logic [isoc_pkg::COUNT_W-1:0] total_next;

	assign hit        = inside_s1 && match_next;
	assign total_next = (hit && total_q != isoc_pkg::COUNT_MAX)
		? total_q + isoc_pkg::COUNT_W'(1) : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (s1_adv) begin
			total_q <= end_s1 ? '0 : total_next;
		end
	end

	// output register
	isoc_pkg::out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.window_match <= hit;
			out_q.object_count <= total_next;
			out_q.frame_end    <= end_s1;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_q;

endmodule

`default_nettype wire
